>>> sv/positional_ordered_list_macros.svh
// Assertion macros used by the ordered list top level.
`ifndef POSITIONAL_ORDERED_LIST_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define POL_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("ordered list invariant violated");

// Checks that a condition holds in the cycle after the trigger.
`define POL_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("ordered list sequence check failed");

`endif

>>> sv/pol_pkg.sv
// Types, codes and sizes shared by the ordered list modules.
package pol_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int REQ_WIDTH   = 3;
   localparam int STAT_WIDTH  = 2;
   localparam int OP_WIDTH    = 2;

   localparam logic [REQ_WIDTH-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_WIDTH-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_WIDTH-1:0] REQ_INSERT     = 3'd2;
   localparam logic [REQ_WIDTH-1:0] REQ_REMOVE     = 3'd3;
   localparam logic [REQ_WIDTH-1:0] REQ_READ       = 3'd4;

   localparam logic [STAT_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_WIDTH-1:0] ST_RANGE = 2'd2;

   localparam logic [OP_WIDTH-1:0] CELL_HOLD   = 2'd0;
   localparam logic [OP_WIDTH-1:0] CELL_INSERT = 2'd1;
   localparam logic [OP_WIDTH-1:0] CELL_REMOVE = 2'd2;

   typedef struct packed {
      logic [REQ_WIDTH-1:0]          req_type;
      logic signed [DATA_WIDTH-1:0]  value;
      logic [COUNT_WIDTH-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [STAT_WIDTH-1:0]         status;
      logic [COUNT_WIDTH-1:0]        entry_count;
      logic signed [DATA_WIDTH-1:0]  read_value;
   } rsp_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]           op;
      logic [COUNT_WIDTH-1:0]        pos;
      logic signed [DATA_WIDTH-1:0]  data;
   } cmd_type;

endpackage

>>> sv/pol_cell.sv
// One storage cell of the list: holds an entry, loads, shifts back or forward.
module pol_cell (
   input  logic                                   clock,
   input  pol_pkg::cmd_type                       cmd,
   input  logic [pol_pkg::COUNT_WIDTH-1:0]        index,
   input  logic signed [pol_pkg::DATA_WIDTH-1:0]  left_data,
   input  logic signed [pol_pkg::DATA_WIDTH-1:0]  right_data,
   output logic signed [pol_pkg::DATA_WIDTH-1:0]  data
);
   import pol_pkg::*;

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (index == cmd.pos) begin
               data_in = cmd.data;
            end else if (index > cmd.pos) begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (index >= cmd.pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> sv/pol_chain.sv
// Row of list cells linked to their neighbors, with the positional read select.
module pol_chain (
   input  logic                                   clock,
   input  pol_pkg::cmd_type                       cmd,
   output logic signed [pol_pkg::DATA_WIDTH-1:0]  read_data
);
   import pol_pkg::*;

   logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_data;
      logic signed [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_left
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_right
         assign right_data = cell_data[i+1];
      end

      pol_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (COUNT_WIDTH'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | (cell_data[i] & {DATA_WIDTH{cmd.pos == COUNT_WIDTH'(i)}});
      end
   end

endmodule

>>> sv/positional_ordered_list.sv
// Top level of the bounded ordered list with request decode and response register.
//
// Requests arrive on req_valid/req_ready/req_data and push at the front,
// append at the back, insert at a position, remove at a position or read at
// a position. Each accepted request produces exactly one response on
// rsp_valid/rsp_ready/rsp_data with a status, the count after the request
// and the value read or removed.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while rsp_ready is high, set by the row
// of cells, where those at and past the position load or shift in the same cycle.
// A new request is taken while a response waits only if that response is
// taken in the same cycle; while the receiver stalls, req_ready stays low
// and the held response does not change.
// Reset clears the count and the response valid; the entries themselves are
// not cleared, since only positions below the count are ever read.
module positional_ordered_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pol_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pol_pkg::rsp_type  rsp_data
);
   import pol_pkg::*;
   `include "positional_ordered_list_macros.svh"

   logic                          req_accept;
   logic                          is_put;
   logic [COUNT_WIDTH-1:0]        op_pos;
   logic [OP_WIDTH-1:0]           op_sel;
   cmd_type                       cmd;
   logic signed [DATA_WIDTH-1:0]  read_data;

   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      is_put = 1'b0;
      op_pos = req_data.position;
      unique case (req_data.req_type)
         REQ_PUSH_FRONT: begin
            is_put = 1'b1;
            op_pos = '0;
         end
         REQ_PUSH_BACK: begin
            is_put = 1'b1;
            op_pos = count_ff;
         end
         REQ_INSERT: begin
            is_put = 1'b1;
         end
         default: begin
            is_put = 1'b0;
         end
      endcase
   end

   always_comb begin
      op_sel             = CELL_HOLD;
      count_in           = count_ff;
      rsp_in.status      = ST_RANGE;
      rsp_in.read_value  = '0;
      priority if (is_put) begin
         if (count_ff == COUNT_WIDTH'(DEPTH)) begin
            rsp_in.status = ST_FULL;
         end else if (op_pos <= count_ff) begin
            rsp_in.status = ST_DONE;
            op_sel        = CELL_INSERT;
            count_in      = count_ff + COUNT_WIDTH'(1);
         end
      end else if ((req_data.req_type == REQ_REMOVE || req_data.req_type == REQ_READ)
                   && op_pos < count_ff) begin
         rsp_in.status     = ST_DONE;
         rsp_in.read_value = read_data;
         if (req_data.req_type == REQ_REMOVE) begin
            op_sel   = CELL_REMOVE;
            count_in = count_ff - COUNT_WIDTH'(1);
         end
      end else begin
         rsp_in.status = ST_RANGE;
      end
      rsp_in.entry_count = count_in;
   end

   assign cmd.op   = req_accept ? op_sel : CELL_HOLD;
   assign cmd.pos  = op_pos;
   assign cmd.data = req_data.value;

   pol_chain u_chain (
      .clock     (clock),
      .cmd       (cmd),
      .read_data (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `POL_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_WIDTH'(DEPTH))
   `POL_ASSERT_NEXT(a_insert_grows, req_accept && op_sel == CELL_INSERT,
                    count_ff == $past(count_ff) + COUNT_WIDTH'(1))
   `POL_ASSERT_NEXT(a_fail_holds, req_accept && rsp_in.status != ST_DONE,
                    count_ff == $past(count_ff) && rsp_valid_ff)
   `POL_ASSERT_NEXT(a_count_reported, req_accept, rsp_ff.entry_count == count_ff)

endmodule
